### rtl/nrlbd_pkg.sv
`timescale 1ns / 1ps

package nrlbd_pkg;

    localparam int COORD_BITS = 8;
    localparam int PIX_BITS   = 8;
    localparam int CODE_BITS  = 8;
    localparam int NIB_BITS   = 4;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 8;
    localparam int M_DATA_W   = 24;

    localparam logic [CFG_DW-1:0] WIDTH_RESET = 8'd128;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [NIB_BITS-1:0]   nib_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_ORIGIN_X    = 3'd1,
        REG_ORIGIN_Y    = 3'd2,
        REG_SLIDE_MODE  = 3'd3,
        REG_SLIDE_ROW   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

### rtl/nibble_run_length_bitmap_decoder_top.sv
`timescale 1ns / 1ps

// nibble run-length decoder for 1-bit images
// input channel (s_): one code word per transfer; high nibble is a black run,
// low nibble a white run; s_tlast marks the final word of an image and
// returns the cursor to the top left once that word is decoded
// output channel (m_): one pixel draw per word, x and y already offset by
// the origin registers; m_tlast flags the last pixel drawn for an input word
// config port: cfg_we/cfg_addr/cfg_wdata write image_width, origin_x,
// origin_y, slide_mode and slide_row; write only while the decoder is idle
// sequence: a word is loaded while idle, then its runs are stepped one
// pixel at a time, then a closing step returns to idle; a single
// cursor step unit is reused for every pixel, and s_tready is low until
// the word is finished
// a stalled receiver holds the step unit: a pixel that must be drawn waits
// until the output register frees, slide-mode black steps never wait
// reset: synchronous, active low; clears cursor, counters and valid flags
// and loads the register defaults (width 128, everything else zero)
module nibble_run_length_bitmap_decoder_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [nrlbd_pkg::CODE_BITS-1:0]  s_tdata,   // code_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [nrlbd_pkg::M_DATA_W-1:0]   m_tdata,   // pixel_x, pixel_y, pixel_colour, zeros
    output logic                             m_tlast,   // run_end
    input  logic                             cfg_we,
    input  logic [nrlbd_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [nrlbd_pkg::CFG_DW-1:0]     cfg_wdata
);
    import nrlbd_pkg::*;

    state_t              st_reg, st_next;
    nib_t                blk_reg, blk_next;
    nib_t                wht_reg, wht_next;
    logic                last_reg, last_next;
    coord_t              col_reg, col_next;
    coord_t              row_reg, row_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [PIX_BITS-1:0] px_reg, px_next;
    logic [PIX_BITS-1:0] py_reg, py_next;
    logic                pc_reg, pc_next;
    logic                pend_reg, pend_next;

    logic [CFG_DW-1:0]   width_reg;
    logic [CFG_DW-1:0]   org_x_reg;
    logic [CFG_DW-1:0]   org_y_reg;
    logic                slide_reg;
    logic [CFG_DW-1:0]   slide_row_reg;

    logic                out_free;
    coord_t              col_inc;
    coord_t              col_adv;
    coord_t              row_adv;
    coord_t              sum_x;
    coord_t              sum_y;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RESET;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            slide_reg     <= 1'b0;
            slide_row_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH: width_reg     <= cfg_wdata;
                REG_ORIGIN_X:    org_x_reg     <= cfg_wdata;
                REG_ORIGIN_Y:    org_y_reg     <= cfg_wdata;
                REG_SLIDE_MODE:  slide_reg     <= cfg_wdata[0];
                REG_SLIDE_ROW:   slide_row_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared cursor step unit
    always_comb begin
        col_inc = col_reg + coord_t'(1);
        if (col_inc >= coord_t'(width_reg)) begin
            col_adv = '0;
            row_adv = row_reg + coord_t'(1);
        end else begin
            col_adv = col_inc;
            row_adv = row_reg;
        end
        sum_x = coord_t'(org_x_reg) + col_reg;
        sum_y = coord_t'(org_y_reg) + row_reg;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    st_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (blk_reg == '0 && wht_reg == '0) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_tready      = (st_reg == ST_IDLE);
        blk_next      = blk_reg;
        wht_next      = wht_reg;
        last_next     = last_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        m_tvalid_next = m_tvalid_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pc_next       = pc_reg;
        pend_next     = pend_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    blk_next  = s_tdata[CODE_BITS-1:NIB_BITS];
                    wht_next  = s_tdata[NIB_BITS-1:0];
                    last_next = s_tlast;
                end
            end
            ST_RUN: begin
                priority if (blk_reg != '0) begin
                    if (slide_reg) begin
                        blk_next = blk_reg - nib_t'(1);
                        col_next = col_adv;
                        row_next = row_adv;
                    end else if (out_free) begin
                        m_tvalid_next = 1'b1;
                        px_next       = sum_x[PIX_BITS-1:0];
                        py_next       = sum_y[PIX_BITS-1:0];
                        pc_next       = 1'b0;
                        pend_next     = (blk_reg == nib_t'(1)) && (wht_reg == '0);
                        blk_next      = blk_reg - nib_t'(1);
                        col_next      = col_adv;
                        row_next      = row_adv;
                    end
                end else if (wht_reg != '0) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        px_next       = sum_x[PIX_BITS-1:0];
                        py_next       = sum_y[PIX_BITS-1:0];
                        pc_next       = !(slide_reg && (row_reg < coord_t'(slide_row_reg)));
                        pend_next     = (wht_reg == nib_t'(1));
                        wht_next      = wht_reg - nib_t'(1);
                        col_next      = col_adv;
                        row_next      = row_adv;
                    end
                end else begin
                    if (last_reg) begin
                        col_next = '0;
                        row_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            blk_reg      <= '0;
            wht_reg      <= '0;
            last_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            blk_reg      <= blk_next;
            wht_reg      <= wht_next;
            last_reg     <= last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        pc_reg   <= pc_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = pend_reg;
    assign m_tdata  = {{(M_DATA_W - 2 * PIX_BITS - 1){1'b0}}, pc_reg, py_reg, px_reg};

    // checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("decoder ready right after taking a word");

    a_idle_counts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_IDLE |-> blk_reg == '0 && wht_reg == '0)
        else $error("run counters left over in idle");

    a_last_resets_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_RUN && blk_reg == '0 && wht_reg == '0 && last_reg
        |=> col_reg == '0 && row_reg == '0)
        else $error("cursor not returned after final word");

endmodule

### verif/nrlbd_pixel_checker.sv
`timescale 1ns / 1ps

module nrlbd_pixel_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [nrlbd_pkg::CODE_BITS-1:0] s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [nrlbd_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [nrlbd_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [nrlbd_pkg::CFG_DW-1:0]    cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    import nrlbd_pkg::*;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   colour;
        logic   run_end;
    } pixel_t;

    pixel_t draw_q[$];

    coord_t image_width;
    coord_t origin_x;
    coord_t origin_y;
    logic   slide_on;
    coord_t slide_row;
    coord_t cur_col;
    coord_t cur_row;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    task automatic step_cursor();
        cur_col = cur_col + 1'b1;
        if (cur_col >= image_width) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
    endtask

    task automatic queue_draw(input logic colour, input logic is_end);
        pixel_t p;
        p.x = origin_x + cur_col;
        p.y = origin_y + cur_row;
        p.colour = colour;
        p.run_end = is_end;
        draw_q.push_back(p);
    endtask

    task automatic decode_word(input logic [CODE_BITS-1:0] code, input logic last_word);
        nib_t black;
        nib_t white;
        int   total;
        int   k;
        int   i;
        black = code[CODE_BITS-1 -: NIB_BITS];
        white = code[NIB_BITS-1:0];
        total = (slide_on ? 0 : int'(black)) + int'(white);
        k = 0;
        for (i = 0; i < int'(black); i++) begin
            if (!slide_on) begin
                queue_draw(1'b0, k == total - 1);
                k++;
            end
            step_cursor();
        end
        // slide mode: white drawn black above the slide row
        for (i = 0; i < int'(white); i++) begin
            queue_draw(!(slide_on && cur_row < slide_row), k == total - 1);
            k++;
            step_cursor();
        end
        if (last_word) begin
            cur_col = '0;
            cur_row = '0;
        end
    endtask

    task automatic check_draw();
        pixel_t want;
        if (draw_q.size() == 0) begin
            $error("pixel word with nothing pending: x %0d y %0d colour %0d",
                   m_tdata[7:0], m_tdata[15:8], m_tdata[16]);
            fail_count++;
            return;
        end
        want = draw_q.pop_front();
        if (m_tdata[7:0] !== want.x) begin
            $error("pixel_x expected %0d actual %0d", want.x, m_tdata[7:0]);
            fail_count++;
        end
        if (m_tdata[15:8] !== want.y) begin
            $error("pixel_y expected %0d actual %0d", want.y, m_tdata[15:8]);
            fail_count++;
        end
        if (m_tdata[16] !== want.colour) begin
            $error("pixel_colour expected %0d actual %0d", want.colour, m_tdata[16]);
            fail_count++;
        end
        if (m_tlast !== want.run_end) begin
            $error("run_end expected %0d actual %0d", want.run_end, m_tlast);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            image_width = WIDTH_RESET;
            origin_x = '0;
            origin_y = '0;
            slide_on = 1'b0;
            slide_row = '0;
            cur_col = '0;
            cur_row = '0;
            draw_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_IMAGE_WIDTH: image_width = cfg_wdata;
                    REG_ORIGIN_X:    origin_x = cfg_wdata;
                    REG_ORIGIN_Y:    origin_y = cfg_wdata;
                    REG_SLIDE_MODE:  slide_on = cfg_wdata[0];
                    REG_SLIDE_ROW:   slide_row = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_word(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_draw();
            end
        end
        pending = draw_q.size();
    end

endmodule

### verif/tb_nibble_run_length_bitmap_decoder_top.sv
`timescale 1ns / 1ps

module tb_nibble_run_length_bitmap_decoder_top;
    import nrlbd_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 30;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CODE_BITS-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left = 0;
    bit steady = 1'b0;

    nibble_run_length_bitmap_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    nrlbd_pixel_checker u_pixel_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // receiver back-pressure
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_left = gap_len();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_word(input logic [CODE_BITS-1:0] code, input logic last_word);
        int gap;
        gap = gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        s_tlast <= last_word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drain all pending draws, then let any empty word finish
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
    endtask

    task automatic configure(input logic [CFG_DW-1:0] width, input logic [CFG_DW-1:0] org_x,
                             input logic [CFG_DW-1:0] org_y, input logic slide,
                             input logic [CFG_DW-1:0] srow);
        settle();
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_ORIGIN_X, org_x);
        write_reg(REG_ORIGIN_Y, org_y);
        write_reg(REG_SLIDE_MODE, {{(CFG_DW-1){1'b0}}, slide});
        write_reg(REG_SLIDE_ROW, srow);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int p;
        int i;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: empty word, full runs
        push_word(8'h00, 1'b0);
        push_word(8'hF0, 1'b0);
        push_word(8'h0F, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h11, 1'b0);
        push_word(8'hA5, 1'b1);

        // one-pixel rows: row and coordinate wrap
        configure(8'd1, 8'd250, 8'd250, 1'b0, 8'd0);
        for (i = 0; i < 9; i++) begin
            push_word(8'hFF, i == 8);
        end

        // zero width
        configure(8'd0, 8'd3, 8'd7, 1'b0, 8'd0);
        push_word(8'h21, 1'b0);
        push_word(8'h12, 1'b1);

        // slide mode, black-only words give no draws
        configure(8'd4, 8'd0, 8'd0, 1'b1, 8'd2);
        push_word(8'h0F, 1'b0);
        push_word(8'h40, 1'b0);
        push_word(8'h50, 1'b1);
        push_word(8'h03, 1'b0);

        // width shrunk below the current column
        configure(8'd200, 8'd0, 8'd0, 1'b0, 8'd0);
        push_word(8'hF0, 1'b0);
        push_word(8'hF0, 1'b0);
        push_word(8'h0F, 1'b0);
        configure(8'd10, 8'd0, 8'd0, 1'b0, 8'd0);
        push_word(8'h02, 1'b0);
        push_word(8'h01, 1'b1);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p % 4 == 3);
            case (p)
                0: configure(8'd255, 8'd255, 8'd0, 1'b1, 8'd255);
                1: configure(8'd1, 8'd0, 8'd255, 1'b0, 8'd0);
                default: configure(CFG_DW'(($urandom_range(0, 9) == 0)
                                           ? $urandom_range(128, 255)
                                           : $urandom_range(1, 24)),
                                   CFG_DW'($urandom_range(0, 255)),
                                   CFG_DW'($urandom_range(0, 255)),
                                   1'($urandom_range(0, 1)),
                                   CFG_DW'($urandom_range(0, 12)));
            endcase
            for (i = 0; i < PHASE_WORDS; i++) begin
                push_word(CODE_BITS'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
            end
        end
        steady = 1'b0;

        settle();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/nrlbd_pkg.sv
rtl/nibble_run_length_bitmap_decoder_top.sv
verif/nrlbd_pixel_checker.sv
verif/tb_nibble_run_length_bitmap_decoder_top.sv
